### rtl/obd_pid_responder_top_macros.svh
// Assertion macros for the OBD PID responder.
// Included by the top level; depends on nothing else.
`ifndef OBD_PID_RESPONDER_TOP_MACROS_SVH
`define OBD_PID_RESPONDER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define OBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define OBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/obd_pkg.sv
// Shared types for the OBD PID responder: command codes, the telemetry
// state record and the reply record. No dependencies.
package obd_pkg;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_MODE01 = 2'd1,
    CMD_MODE22 = 2'd2
  } obd_cmd_t;

  // Telemetry held in Q8 unless noted; temperatures and spark advance are
  // two's complement, the rest are non-negative.
  typedef struct packed {
    logic [21:0] engine_speed;
    logic [15:0] vehicle_speed;
    logic [16:0] coolant_temp;
    logic [16:0] intake_temp;
    logic [14:0] engine_load;
    logic [14:0] throttle_pos;
    logic [15:0] manifold_pressure;
    logic [17:0] air_flow;
    logic [15:0] spark_advance;
    logic [16:0] oil_temp;
    logic [14:0] battery_volts;
    logic [14:0] fuel_level;
    logic [15:0] run_seconds;   // whole seconds
    logic [5:0]  lamp_flags;
  } obd_state_t;

  typedef struct packed {
    logic        has_result;
    logic        status;
    logic [7:0]  service;
    logic [15:0] id;
    logic [2:0]  count;
    logic [31:0] payload;
  } obd_reply_t;

endpackage

### rtl/obd_state.sv
// Telemetry register file of the OBD PID responder: clamps and stores one
// update per cycle. Depends on obd_pkg.
module obd_state
  import obd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd_en,
  input  logic [4:0]         quantity,
  input  logic signed [31:0] new_value,
  output obd_state_t         state
);

  localparam logic [4:0] Q_ENGINE_SPEED = 5'd0;
  localparam logic [4:0] Q_VEHICLE_SPEED = 5'd1;
  localparam logic [4:0] Q_COOLANT = 5'd2;
  localparam logic [4:0] Q_INTAKE = 5'd3;
  localparam logic [4:0] Q_LOAD = 5'd4;
  localparam logic [4:0] Q_THROTTLE = 5'd5;
  localparam logic [4:0] Q_MANIFOLD = 5'd6;
  localparam logic [4:0] Q_AIR_FLOW = 5'd7;
  localparam logic [4:0] Q_SPARK = 5'd8;
  localparam logic [4:0] Q_OIL = 5'd9;
  localparam logic [4:0] Q_VOLTS = 5'd10;
  localparam logic [4:0] Q_FUEL = 5'd11;
  localparam logic [4:0] Q_RUN_SECONDS = 5'd12;
  localparam logic [4:0] Q_LAMP_FIRST = 5'd13;
  localparam logic [4:0] Q_LAMP_LAST = 5'd18;

  obd_state_t state_r, state_nxt;

  function automatic logic [31:0] clamp_q8(logic signed [31:0] v,
                                          logic signed [31:0] lo,
                                          logic signed [31:0] hi);
    logic [31:0] res;
    if (v < lo) res = lo;
    else if (v > hi) res = hi;
    else res = v;
    return res;
  endfunction

  logic [31:0] run_clamped;
  logic [4:0]  lamp_idx;

  always_comb begin
    run_clamped = clamp_q8(new_value, 32'sd0, 32'sd16776960);
    lamp_idx = quantity - Q_LAMP_FIRST;
    state_nxt = state_r;
    if (upd_en) begin
      case (quantity)
        Q_ENGINE_SPEED:
          state_nxt.engine_speed = 22'(clamp_q8(new_value, 32'sd0, 32'sd4194240));
        Q_VEHICLE_SPEED:
          state_nxt.vehicle_speed = 16'(clamp_q8(new_value, 32'sd0, 32'sd65280));
        Q_COOLANT:
          state_nxt.coolant_temp = 17'(clamp_q8(new_value, -32'sd10240, 32'sd55040));
        Q_INTAKE:
          state_nxt.intake_temp = 17'(clamp_q8(new_value, -32'sd10240, 32'sd55040));
        Q_LOAD:
          state_nxt.engine_load = 15'(clamp_q8(new_value, 32'sd0, 32'sd25600));
        Q_THROTTLE:
          state_nxt.throttle_pos = 15'(clamp_q8(new_value, 32'sd0, 32'sd25600));
        Q_MANIFOLD:
          state_nxt.manifold_pressure = 16'(clamp_q8(new_value, 32'sd0, 32'sd65280));
        Q_AIR_FLOW:
          state_nxt.air_flow = 18'(clamp_q8(new_value, 32'sd0, 32'sd167769));
        Q_SPARK:
          state_nxt.spark_advance = 16'(clamp_q8(new_value, -32'sd16384, 32'sd16256));
        Q_OIL:
          state_nxt.oil_temp = 17'(clamp_q8(new_value, -32'sd10240, 32'sd55040));
        Q_VOLTS:
          state_nxt.battery_volts = 15'(clamp_q8(new_value, 32'sd0, 32'sd16640));
        Q_FUEL:
          state_nxt.fuel_level = 15'(clamp_q8(new_value, 32'sd0, 32'sd25600));
        Q_RUN_SECONDS:
          state_nxt.run_seconds = run_clamped[23:8];
        default: begin
          // Lamp quantities turn on at one half or more.
          if (quantity >= Q_LAMP_FIRST && quantity <= Q_LAMP_LAST) begin
            state_nxt.lamp_flags[lamp_idx[2:0]] = (new_value >= 32'sd128);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.engine_speed <= 22'd230400;
      state_r.vehicle_speed <= 16'd0;
      state_r.coolant_temp <= 17'd20480;
      state_r.intake_temp <= 17'd7168;
      state_r.engine_load <= 15'd3072;
      state_r.throttle_pos <= 15'd0;
      state_r.manifold_pressure <= 16'd8960;
      state_r.air_flow <= 18'd896;
      state_r.spark_advance <= 16'd2048;
      state_r.oil_temp <= 17'd21760;
      state_r.battery_volts <= 15'd3533;
      state_r.fuel_level <= 15'd19200;
      state_r.run_seconds <= 16'd120;
      state_r.lamp_flags <= 6'd0;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

### rtl/obd_resp.sv
// Reply formatter of the OBD PID responder: decodes a mode 01 or mode 22
// query against the telemetry state. Pure logic; depends on obd_pkg.
module obd_resp
  import obd_pkg::*;
(
  input  logic [1:0]  command,
  input  logic [15:0] request_id,
  input  obd_state_t  state,
  output obd_reply_t  reply
);

  localparam logic [7:0] PID_MASK_01_20 = 8'h00;
  localparam logic [7:0] PID_STATUS = 8'h01;
  localparam logic [7:0] PID_LOAD = 8'h04;
  localparam logic [7:0] PID_COOLANT = 8'h05;
  localparam logic [7:0] PID_MANIFOLD = 8'h0B;
  localparam logic [7:0] PID_RPM = 8'h0C;
  localparam logic [7:0] PID_SPEED = 8'h0D;
  localparam logic [7:0] PID_SPARK = 8'h0E;
  localparam logic [7:0] PID_INTAKE = 8'h0F;
  localparam logic [7:0] PID_MAF = 8'h10;
  localparam logic [7:0] PID_THROTTLE = 8'h11;
  localparam logic [7:0] PID_RUN_TIME = 8'h1F;
  localparam logic [7:0] PID_MASK_21_40 = 8'h20;
  localparam logic [7:0] PID_FUEL = 8'h2F;
  localparam logic [7:0] PID_LAMP_FIRST = 8'h30;
  localparam logic [7:0] PID_LAMP_LAST = 8'h35;
  localparam logic [7:0] PID_LAMPS = 8'h3A;
  localparam logic [7:0] PID_MASK_41_60 = 8'h40;
  localparam logic [7:0] PID_VOLTS = 8'h42;
  localparam logic [7:0] PID_OIL = 8'h5C;
  localparam logic [15:0] DID_LAMP_FIRST = 16'h1001;
  localparam logic [15:0] DID_LAMP_LAST = 16'h1006;
  localparam logic [15:0] DID_LAMPS = 16'h100A;
  localparam logic [31:0] MASK_01_20 = 32'h983F8003;
  localparam logic [31:0] MASK_21_40 = 32'h0003F801;
  localparam logic [31:0] MASK_41_60 = 32'h40000011;
  localparam logic [31:0] STATUS_MIL = 32'h81000000;
  localparam logic [7:0] SVC_MODE01 = 8'h41;
  localparam logic [7:0] SVC_MODE22 = 8'h62;

  // floor(v * 255 / 25600): the divide by 100 is a multiply by 5243 / 2^19,
  // exact for every value up to 25500.
  function automatic logic [7:0] pct_byte(logic [14:0] v);
    logic [22:0] scaled;
    logic [27:0] prod;
    scaled = {v, 8'd0} - {8'd0, v};
    prod = 28'(scaled[22:8]) * 28'd5243;
    return prod[26:19];
  endfunction

  function automatic logic [7:0] temp_byte(logic [16:0] v);
    logic [16:0] shifted;
    shifted = v + 17'd10240;
    return shifted[15:8];
  endfunction

  logic [7:0]  pid;
  logic [7:0]  pid_off;
  logic [15:0] did_off;
  logic [24:0] maf_prod;
  logic [23:0] volt_prod;
  logic [15:0] spark_shift;
  logic [31:0] data;
  logic [2:0]  count;
  logic [7:0]  service;
  logic [15:0] id;

  always_comb begin
    pid = request_id[7:0];
    pid_off = pid - PID_LAMP_FIRST;
    did_off = request_id - DID_LAMP_FIRST;
    maf_prod = 25'(state.air_flow) * 25'd100;
    volt_prod = 24'(state.battery_volts) * 24'd1000;
    spark_shift = state.spark_advance + 16'd16384;
    data = 32'd0;
    count = 3'd0;
    service = 8'd0;
    id = 16'd0;
    reply.has_result = 1'b1;
    case (obd_cmd_t'(command))
      CMD_MODE01: begin
        service = SVC_MODE01;
        id = {8'd0, pid};
        case (pid)
          PID_MASK_01_20: begin data = MASK_01_20; count = 3'd4; end
          PID_MASK_21_40: begin data = MASK_21_40; count = 3'd4; end
          PID_MASK_41_60: begin data = MASK_41_60; count = 3'd4; end
          PID_STATUS: begin
            data = state.lamp_flags[5] ? STATUS_MIL : 32'd0;
            count = 3'd4;
          end
          PID_LOAD: begin data = {pct_byte(state.engine_load), 24'd0}; count = 3'd1; end
          PID_COOLANT: begin data = {temp_byte(state.coolant_temp), 24'd0}; count = 3'd1; end
          PID_MANIFOLD: begin data = {state.manifold_pressure[15:8], 24'd0}; count = 3'd1; end
          PID_RPM: begin data = {state.engine_speed[21:6], 16'd0}; count = 3'd2; end
          PID_SPEED: begin data = {state.vehicle_speed[15:8], 24'd0}; count = 3'd1; end
          PID_SPARK: begin data = {spark_shift[14:7], 24'd0}; count = 3'd1; end
          PID_INTAKE: begin data = {temp_byte(state.intake_temp), 24'd0}; count = 3'd1; end
          PID_MAF: begin data = {maf_prod[23:8], 16'd0}; count = 3'd2; end
          PID_THROTTLE: begin data = {pct_byte(state.throttle_pos), 24'd0}; count = 3'd1; end
          PID_RUN_TIME: begin data = {state.run_seconds, 16'd0}; count = 3'd2; end
          PID_FUEL: begin data = {pct_byte(state.fuel_level), 24'd0}; count = 3'd1; end
          PID_LAMPS: begin data = {2'd0, state.lamp_flags, 24'd0}; count = 3'd1; end
          PID_VOLTS: begin data = {volt_prod[23:8], 16'd0}; count = 3'd2; end
          PID_OIL: begin data = {temp_byte(state.oil_temp), 24'd0}; count = 3'd1; end
          default: begin
            if (pid >= PID_LAMP_FIRST && pid <= PID_LAMP_LAST) begin
              data = {7'd0, state.lamp_flags[pid_off[2:0]], 24'd0};
              count = 3'd1;
            end
          end
        endcase
      end
      CMD_MODE22: begin
        service = SVC_MODE22;
        id = request_id;
        if (request_id >= DID_LAMP_FIRST && request_id <= DID_LAMP_LAST) begin
          data = {7'd0, state.lamp_flags[did_off[2:0]], 24'd0};
          count = 3'd1;
        end else if (request_id == DID_LAMPS) begin
          data = {2'd0, state.lamp_flags, 24'd0};
          count = 3'd1;
        end
      end
      default: reply.has_result = 1'b0;
    endcase

    // An unknown PID or DID answers with every field but status cleared.
    reply.status = (count == 3'd0);
    reply.service = reply.status ? 8'd0 : service;
    reply.id = reply.status ? 16'd0 : id;
    reply.count = count;
    reply.payload = data;
  end

endmodule

### rtl/obd_pid_responder_top.sv
// Top level of the OBD PID responder: input register, state file, reply
// formatter and output register. Depends on obd_pkg, obd_state, obd_resp
// and obd_pid_responder_top_macros.svh.
//
// Use: each input beat is an update (command 0) or a query (mode 01 or
// mode 22). An update writes one telemetry quantity and gives no result
// beat; each query gives exactly one result beat, including a no-data
// beat for an unknown PID or DID. Command code 3 is dropped silently.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. A taken beat sits in the input register, is decoded there by
// combinational logic and is captured in the output register, which
// raises out_valid, once that register is free. One beat per cycle is
// sustained in both directions while out_stall stays low; the data path
// is one pass of clamp or scaling logic between the two registers, while
// out_stall reaches in_stall through a few gates in the same cycle.
// Updates take effect at the edge they leave the input register, so the
// very next query already sees the new value.
// While out_stall holds a result, the output register keeps it; a query
// waiting behind it raises in_stall, while updates keep draining.
// Reset (rst_n low at a clock edge) empties both registers and restores
// the power-on telemetry values.
`include "obd_pid_responder_top_macros.svh"

module obd_pid_responder_top
  import obd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [4:0]         in_quantity,
  input  logic signed [31:0] in_new_value,
  input  logic [15:0]        in_request_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic [7:0]         out_reply_service,
  output logic [15:0]        out_reply_id,
  output logic [2:0]         out_byte_count,
  output logic [31:0]        out_payload
);

  // Input register.
  logic               s1_valid_r;
  logic [1:0]         s1_command_r;
  logic [4:0]         s1_quantity_r;
  logic signed [31:0] s1_new_value_r;
  logic [15:0]        s1_request_id_r;

  // Output register.
  logic       out_valid_r;
  obd_reply_t out_r;

  obd_state_t state;
  obd_reply_t reply;
  logic       out_free;
  logic       s1_adv;
  logic       upd_en;

  // The output register can take a new result when it is empty or its
  // current beat leaves this cycle. An item that makes no result never
  // waits on it.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv = s1_valid_r && (!reply.has_result || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign upd_en = s1_adv && (s1_command_r == CMD_UPDATE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_command_r <= in_command;
      s1_quantity_r <= in_quantity;
      s1_new_value_r <= in_new_value;
      s1_request_id_r <= in_request_id;
    end
  end

  obd_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_en    (upd_en),
    .quantity  (s1_quantity_r),
    .new_value (s1_new_value_r),
    .state     (state)
  );

  obd_resp u_resp (
    .command    (s1_command_r),
    .request_id (s1_request_id_r),
    .state      (state),
    .reply      (reply)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && reply.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && reply.has_result) begin
      out_r <= reply;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_r.status;
  assign out_reply_service = out_r.service;
  assign out_reply_id = out_r.id;
  assign out_byte_count = out_r.count;
  assign out_payload = out_r.payload;

  // A query that leaves the input register always lands in the output register.
  `OBD_ASSERT_NEXT(a_query_lands, s1_adv && reply.has_result, out_valid_r, "query result lost")
  // The input side only stalls behind a result that is itself held.
  `OBD_ASSERT_NOW(a_stall_cause, in_stall, s1_valid_r && out_valid_r && out_stall, "spurious in_stall")
  // A no-data beat carries nothing; a data beat carries at least one byte.
  `OBD_ASSERT_NOW(a_no_data_form, out_valid_r, (out_r.status == (out_r.count == 3'd0)) && (!out_r.status || (out_r.service == 8'd0 && out_r.payload == 32'd0)), "malformed reply")

endmodule

### dv/obd_pid_responder_top_tb.sv
// Self-checking testbench for obd_pid_responder_top: directed and random
// update and query beats, predicted replies checked in order on the result port.
// Depends on obd_pkg and the RTL of obd_pid_responder_top.
module obd_pid_responder_top_tb;
  import obd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Command code 3 has no package member; the block drops it silently.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [4:0] {
    QTY_ENGINE_SPEED = 5'd0,  QTY_VEHICLE_SPEED = 5'd1, QTY_COOLANT_TEMP = 5'd2,
    QTY_INTAKE_TEMP  = 5'd3,  QTY_ENGINE_LOAD   = 5'd4, QTY_THROTTLE     = 5'd5,
    QTY_MANIFOLD     = 5'd6,  QTY_AIR_FLOW      = 5'd7, QTY_SPARK        = 5'd8,
    QTY_OIL_TEMP     = 5'd9,  QTY_BATTERY       = 5'd10, QTY_FUEL        = 5'd11,
    QTY_RUN_SECONDS  = 5'd12, QTY_LEFT_SIGNAL   = 5'd13, QTY_RIGHT_SIGNAL = 5'd14,
    QTY_HEADLIGHTS   = 5'd15, QTY_DOOR          = 5'd16, QTY_BRAKE       = 5'd17,
    QTY_MIL          = 5'd18, QTY_UNKNOWN       = 5'd31
  } quantity_t;

  localparam logic [7:0] PID_SUPPORT_01_20 = 8'h00;
  localparam logic [7:0] PID_SUPPORT_21_40 = 8'h20;
  localparam logic [7:0] PID_SUPPORT_41_60 = 8'h40;
  localparam logic [7:0] PID_STATUS        = 8'h01;
  localparam logic [7:0] PID_LOAD          = 8'h04;
  localparam logic [7:0] PID_COOLANT       = 8'h05;
  localparam logic [7:0] PID_MANIFOLD      = 8'h0B;
  localparam logic [7:0] PID_RPM           = 8'h0C;
  localparam logic [7:0] PID_SPEED         = 8'h0D;
  localparam logic [7:0] PID_ADVANCE       = 8'h0E;
  localparam logic [7:0] PID_INTAKE        = 8'h0F;
  localparam logic [7:0] PID_AIR_FLOW      = 8'h10;
  localparam logic [7:0] PID_THROTTLE      = 8'h11;
  localparam logic [7:0] PID_RUN_TIME      = 8'h1F;
  localparam logic [7:0] PID_FUEL          = 8'h2F;
  localparam logic [7:0] PID_LAMP_FIRST    = 8'h30;
  localparam logic [7:0] PID_LAMP_LAST     = 8'h35;
  localparam logic [7:0] PID_LAMPS         = 8'h3A;
  localparam logic [7:0] PID_VOLTS         = 8'h42;
  localparam logic [7:0] PID_OIL           = 8'h5C;
  localparam logic [7:0] PID_UNKNOWN       = 8'hFF;

  localparam logic [15:0] DID_LAMP_FIRST = 16'h1001;
  localparam logic [15:0] DID_LAMP_LAST  = 16'h1006;
  localparam logic [15:0] DID_LAMPS      = 16'h100A;
  localparam logic [15:0] DID_UNKNOWN    = 16'hFFFF;

  localparam logic [31:0] MASK_01_20 = 32'h983F8003;
  localparam logic [31:0] MASK_21_40 = 32'h0003F801;
  localparam logic [31:0] MASK_41_60 = 32'h40000011;
  localparam logic [31:0] MIL_STATUS = 32'h81000000;

  localparam logic [7:0] SVC_MODE01 = 8'h41;
  localparam logic [7:0] SVC_MODE22 = 8'h62;
  localparam logic       STATUS_DATA    = 1'b0;
  localparam logic       STATUS_NO_DATA = 1'b1;

  localparam int RANDOM_BEATS = 900;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 400000;

  // One beat of the input channel plus the pacing that goes with it.
  typedef struct {
    logic [1:0]  command;
    logic [4:0]  quantity;
    logic [31:0] new_value;
    logic [15:0] request_id;
    int          phase;
    bit          drain_first;
    bit          start_hold;
  } query_beat_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  service;
    logic [15:0] id;
    logic [2:0]  count;
    logic [31:0] payload;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = '0;
  logic [4:0]         in_quantity = '0;
  logic signed [31:0] in_new_value = '0;
  logic [15:0]        in_request_id = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_status;
  logic [7:0]         out_reply_service;
  logic [15:0]        out_reply_id;
  logic [2:0]         out_byte_count;
  logic [31:0]        out_payload;

  query_beat_t beat_queue[$];
  reply_t      replies_due[$];
  obd_state_t  vehicle;
  int          mismatches = 0;
  logic        in_beat_taken = 1'b0;
  int          drive_phase = 0;
  logic        hold_go = 1'b0;
  int          hold_left = 0;

  obd_pid_responder_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_quantity       (in_quantity),
    .in_new_value      (in_new_value),
    .in_request_id     (in_request_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_reply_service (out_reply_service),
    .out_reply_id      (out_reply_id),
    .out_byte_count    (out_byte_count),
    .out_payload       (out_payload)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle percentages per phase: a slow receiver first, then a slow sender,
  // then both sides running flat out.
  function automatic int idle_pct(int phase, bit receiver);
    case (phase)
      0: return receiver ? 84 : 30;
      1: return receiver ? 30 : 84;
      default: return 0;
    endcase
  endfunction

  function automatic int clamp_q8(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Percent in Q8 scaled to a byte, rounding toward zero.
  function automatic logic [31:0] pct_code(logic [14:0] p);
    return (int'(p) * 255) / 25600;
  endfunction

  // Temperatures are reported with a 40 degree offset.
  function automatic logic [31:0] temp_code(logic [16:0] t);
    return (int'($signed(t)) + 10240) >> 8;
  endfunction

  // Works out the reply to one accepted beat and applies any update to the
  // local copy of the telemetry.
  task automatic respond_to_beat(input logic [1:0] cmd, input logic [4:0] qty,
                                 input logic [31:0] raw, input logic [15:0] rid);
    int          v;
    logic [31:0] data;
    logic [2:0]  n;
    reply_t      rep;
    bit          answered;
    v = int'($signed(raw));
    data = '0;
    n = 3'd0;
    rep = '0;
    answered = 1'b0;
    case (cmd)
      CMD_UPDATE: begin
        case (qty)
          QTY_ENGINE_SPEED:  vehicle.engine_speed = 22'(clamp_q8(v, 0, 4194240));
          QTY_VEHICLE_SPEED: vehicle.vehicle_speed = 16'(clamp_q8(v, 0, 65280));
          QTY_COOLANT_TEMP:  vehicle.coolant_temp = 17'(clamp_q8(v, -10240, 55040));
          QTY_INTAKE_TEMP:   vehicle.intake_temp = 17'(clamp_q8(v, -10240, 55040));
          QTY_ENGINE_LOAD:   vehicle.engine_load = 15'(clamp_q8(v, 0, 25600));
          QTY_THROTTLE:      vehicle.throttle_pos = 15'(clamp_q8(v, 0, 25600));
          QTY_MANIFOLD:      vehicle.manifold_pressure = 16'(clamp_q8(v, 0, 65280));
          QTY_AIR_FLOW:      vehicle.air_flow = 18'(clamp_q8(v, 0, 167769));
          QTY_SPARK:         vehicle.spark_advance = 16'(clamp_q8(v, -16384, 16256));
          QTY_OIL_TEMP:      vehicle.oil_temp = 17'(clamp_q8(v, -10240, 55040));
          QTY_BATTERY:       vehicle.battery_volts = 15'(clamp_q8(v, 0, 16640));
          QTY_FUEL:          vehicle.fuel_level = 15'(clamp_q8(v, 0, 25600));
          QTY_RUN_SECONDS:   vehicle.run_seconds = 16'(clamp_q8(v, 0, 16776960) >> 8);
          default: begin
            // Lamp quantities switch on at one half; higher indices do nothing.
            if (qty >= QTY_LEFT_SIGNAL && qty <= QTY_MIL)
              vehicle.lamp_flags[qty - QTY_LEFT_SIGNAL] = (v >= 128);
          end
        endcase
      end
      CMD_MODE01: begin
        answered = 1'b1;
        rep.service = SVC_MODE01;
        rep.id = {8'h00, rid[7:0]};
        case (rid[7:0])
          PID_SUPPORT_01_20: begin data = MASK_01_20; n = 3'd4; end
          PID_SUPPORT_21_40: begin data = MASK_21_40; n = 3'd4; end
          PID_SUPPORT_41_60: begin data = MASK_41_60; n = 3'd4; end
          PID_STATUS: begin
            data = vehicle.lamp_flags[QTY_MIL - QTY_LEFT_SIGNAL] ? MIL_STATUS : '0;
            n = 3'd4;
          end
          PID_LOAD:     begin data = pct_code(vehicle.engine_load); n = 3'd1; end
          PID_COOLANT:  begin data = temp_code(vehicle.coolant_temp); n = 3'd1; end
          PID_MANIFOLD: begin data = 32'(vehicle.manifold_pressure >> 8); n = 3'd1; end
          PID_RPM:      begin data = 32'(vehicle.engine_speed >> 6); n = 3'd2; end
          PID_SPEED:    begin data = 32'(vehicle.vehicle_speed >> 8); n = 3'd1; end
          PID_ADVANCE: begin
            data = (int'($signed(vehicle.spark_advance)) + 16384) >> 7;
            n = 3'd1;
          end
          PID_INTAKE:   begin data = temp_code(vehicle.intake_temp); n = 3'd1; end
          PID_AIR_FLOW: begin data = (int'(vehicle.air_flow) * 100) >> 8; n = 3'd2; end
          PID_THROTTLE: begin data = pct_code(vehicle.throttle_pos); n = 3'd1; end
          PID_RUN_TIME: begin data = 32'(vehicle.run_seconds); n = 3'd2; end
          PID_FUEL:     begin data = pct_code(vehicle.fuel_level); n = 3'd1; end
          PID_LAMPS:    begin data = 32'(vehicle.lamp_flags); n = 3'd1; end
          PID_VOLTS: begin
            data = (int'(vehicle.battery_volts) * 1000) >> 8;
            n = 3'd2;
          end
          PID_OIL:      begin data = temp_code(vehicle.oil_temp); n = 3'd1; end
          default: begin
            if (rid[7:0] >= PID_LAMP_FIRST && rid[7:0] <= PID_LAMP_LAST) begin
              data = 32'(vehicle.lamp_flags[rid[7:0] - PID_LAMP_FIRST]);
              n = 3'd1;
            end
          end
        endcase
      end
      CMD_MODE22: begin
        answered = 1'b1;
        rep.service = SVC_MODE22;
        rep.id = rid;
        if (rid >= DID_LAMP_FIRST && rid <= DID_LAMP_LAST) begin
          data = 32'(vehicle.lamp_flags[rid - DID_LAMP_FIRST]);
          n = 3'd1;
        end else if (rid == DID_LAMPS) begin
          data = 32'(vehicle.lamp_flags);
          n = 3'd1;
        end
      end
      default: ;
    endcase
    if (answered) begin
      if (n == 3'd0) begin
        // A no-data reply carries nothing but the status bit.
        rep = '0;
        rep.status = STATUS_NO_DATA;
      end else begin
        rep.status = STATUS_DATA;
        rep.count = n;
        rep.payload = (n == 3'd4) ? data : data << (8 * (4 - n));
      end
      replies_due.push_back(rep);
    end
  endtask

  function automatic int field_differs(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, expv, actv);
      return 1;
    end
    return 0;
  endfunction

  function automatic logic [7:0] pick_pid();
    case ($urandom_range(19))
      0:  return PID_SUPPORT_01_20;
      1:  return PID_SUPPORT_21_40;
      2:  return PID_SUPPORT_41_60;
      3:  return PID_STATUS;
      4:  return PID_LOAD;
      5:  return PID_COOLANT;
      6:  return PID_MANIFOLD;
      7:  return PID_RPM;
      8:  return PID_SPEED;
      9:  return PID_ADVANCE;
      10: return PID_INTAKE;
      11: return PID_AIR_FLOW;
      12: return PID_THROTTLE;
      13: return PID_RUN_TIME;
      14: return PID_FUEL;
      15: return PID_LAMPS;
      16: return PID_VOLTS;
      17: return PID_OIL;
      default: return PID_LAMP_FIRST + 8'($urandom_range(5));
    endcase
  endfunction

  // Update values: mostly inside or just outside the clamp ranges, with the
  // full 32-bit space and the two extremes mixed in.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3, 4, 5: return 32'(int'($urandom_range(250000)) - 30000);
      6:       return 32'($urandom_range(255));
      7:       return 32'h7FFFFFFF;
      8:       return 32'h80000000;
      default: return 32'(int'($urandom_range(70000)) - 20000);
    endcase
  endfunction

  task automatic add_beat(input logic [1:0] cmd, input logic [4:0] qty,
                          input logic [31:0] value, input logic [15:0] rid,
                          input int phase = 0, input bit drain = 1'b0,
                          input bit hold = 1'b0);
    query_beat_t b;
    b.command = cmd;
    b.quantity = qty;
    b.new_value = value;
    b.request_id = rid;
    b.phase = phase;
    b.drain_first = drain;
    b.start_hold = hold;
    beat_queue.push_back(b);
  endtask

  // Driver: presents the next pending beat at the falling edge and holds it
  // until the monitor has seen it taken. A beat flagged drain_first is only
  // offered once every reply already owed has come back.
  always @(negedge clk) begin : driver_proc
    query_beat_t nxt;
    bit          holding;
    bit          offer;
    bit          hold_pulse;
    holding = in_valid && !in_beat_taken;
    offer = 1'b0;
    hold_pulse = 1'b0;
    if (rst_n && !holding && beat_queue.size() != 0) begin
      nxt = beat_queue[0];
      if (!(nxt.drain_first && replies_due.size() != 0))
        offer = $urandom_range(99) >= idle_pct(nxt.phase, 1'b0);
    end
    if (offer) begin
      void'(beat_queue.pop_front());
      in_command <= nxt.command;
      in_quantity <= nxt.quantity;
      in_new_value <= nxt.new_value;
      in_request_id <= nxt.request_id;
      in_valid <= 1'b1;
      drive_phase <= nxt.phase;
      hold_pulse = nxt.start_hold;
    end else if (!holding) begin
      in_valid <= 1'b0;
    end
    hold_go <= hold_pulse;
  end

  // The long receiver hold-off is counted here, apart from the driver, so
  // the sender keeps offering beats while the block fills up.
  always @(negedge clk) begin
    if (hold_go)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  always @(negedge clk) begin
    out_stall <= hold_go || (hold_left != 0) ||
                 ($urandom_range(99) < idle_pct(drive_phase, 1'b1));
  end

  // Monitor: samples both channels at the rising edge. Accepted input beats
  // feed the predictor; accepted result beats are checked against the oldest
  // reply still owed.
  always @(posedge clk) begin : monitor_proc
    reply_t due;
    if (!rst_n) begin
      in_beat_taken <= 1'b0;
      vehicle.engine_speed = 22'd230400;
      vehicle.vehicle_speed = '0;
      vehicle.coolant_temp = 17'd20480;
      vehicle.intake_temp = 17'd7168;
      vehicle.engine_load = 15'd3072;
      vehicle.throttle_pos = '0;
      vehicle.manifold_pressure = 16'd8960;
      vehicle.air_flow = 18'd896;
      vehicle.spark_advance = 16'd2048;
      vehicle.oil_temp = 17'd21760;
      vehicle.battery_volts = 15'd3533;
      vehicle.fuel_level = 15'd19200;
      vehicle.run_seconds = 16'd120;
      vehicle.lamp_flags = '0;
    end else begin
      in_beat_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("result beat with no reply owed: id 0x%0h", out_reply_id);
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          mismatches += field_differs("status", due.status, out_status);
          mismatches += field_differs("reply_service", due.service, out_reply_service);
          mismatches += field_differs("reply_id", due.id, out_reply_id);
          mismatches += field_differs("byte_count", due.count, out_byte_count);
          mismatches += field_differs("payload", due.payload, out_payload);
        end
      end
      if (in_valid && !in_stall)
        respond_to_beat(in_command, in_quantity, in_new_value, in_request_id);
    end
  end

  initial begin : stimulus_proc
    int          counted;
    int          phase;
    int          last_phase;
    int          pick;
    logic [1:0]  cmd;
    logic [4:0]  qty;
    logic [31:0] value;
    logic [15:0] rid;
    bit          fresh;

    // Directed part: the supported-PID masks, two with a junk high byte, the
    // saturating extremes of several quantities, the lamp threshold, an
    // unknown quantity, the unused command code and unknown PID and DID.
    add_beat(CMD_MODE01, QTY_UNKNOWN, 32'hFFFFFFFF, {8'hFF, PID_SUPPORT_01_20});
    add_beat(CMD_MODE01, QTY_ENGINE_SPEED, '0, {8'h5A, PID_SUPPORT_21_40});
    add_beat(CMD_MODE01, QTY_ENGINE_SPEED, '0, {8'h00, PID_SUPPORT_41_60});
    add_beat(CMD_MODE01, QTY_ENGINE_SPEED, '0, {8'h00, PID_STATUS});
    add_beat(CMD_UPDATE, QTY_ENGINE_SPEED, 32'h7FFFFFFF, '0);
    add_beat(CMD_MODE01, QTY_ENGINE_SPEED, '0, {8'h00, PID_RPM});
    add_beat(CMD_UPDATE, QTY_ENGINE_SPEED, 32'h80000000, 16'hFFFF);
    add_beat(CMD_MODE01, QTY_ENGINE_SPEED, '0, {8'h00, PID_RPM});
    add_beat(CMD_UPDATE, QTY_MIL, 32'd128, '0);
    add_beat(CMD_MODE01, QTY_ENGINE_SPEED, '0, {8'h00, PID_STATUS});
    add_beat(CMD_UPDATE, QTY_MIL, 32'd127, '0);
    add_beat(CMD_MODE01, QTY_ENGINE_SPEED, '0, {8'h00, PID_STATUS});
    add_beat(CMD_UPDATE, QTY_COOLANT_TEMP, 32'h7FFFFFFF, '0);
    add_beat(CMD_MODE01, QTY_ENGINE_SPEED, '0, {8'h00, PID_COOLANT});
    add_beat(CMD_UPDATE, QTY_SPARK, 32'h80000000, '0);
    add_beat(CMD_MODE01, QTY_ENGINE_SPEED, '0, {8'h00, PID_ADVANCE});
    add_beat(CMD_UPDATE, QTY_RUN_SECONDS, 32'h7FFFFFFF, '0);
    add_beat(CMD_MODE01, QTY_ENGINE_SPEED, '0, {8'h00, PID_RUN_TIME});
    add_beat(CMD_UPDATE, QTY_UNKNOWN, 32'd1, '0);
    add_beat(CMD_UNUSED, QTY_UNKNOWN, 32'hFFFFFFFF, 16'hFFFF);
    add_beat(CMD_MODE01, QTY_ENGINE_SPEED, '0, {8'hFF, PID_UNKNOWN});
    add_beat(CMD_UPDATE, QTY_LEFT_SIGNAL, 32'd256, '0);
    add_beat(CMD_MODE22, QTY_ENGINE_SPEED, '0, DID_LAMP_FIRST);
    add_beat(CMD_MODE22, QTY_ENGINE_SPEED, '0, DID_LAMPS);
    add_beat(CMD_MODE22, QTY_ENGINE_SPEED, '0, DID_UNKNOWN);

    // Random part in three pacing phases. The first beat of each later phase
    // waits for the block to drain; the last phase opens with the long
    // receiver hold-off while the sender runs without gaps.
    counted = 0;
    last_phase = 0;
    while (counted < RANDOM_BEATS) begin
      phase = counted * 3 / RANDOM_BEATS;
      fresh = (phase != last_phase);
      last_phase = phase;
      pick = $urandom_range(99);
      qty = 5'($urandom_range(31));
      value = $urandom;
      rid = 16'($urandom_range(16'hFFFF));
      if (pick < 40) begin
        cmd = CMD_UPDATE;
        if ($urandom_range(9) != 0)
          qty = 5'($urandom_range(QTY_MIL));
        value = pick_value();
      end else if (pick < 75) begin
        cmd = CMD_MODE01;
        if ($urandom_range(4) != 0)
          rid[7:0] = pick_pid();
      end else if (pick < 95) begin
        cmd = CMD_MODE22;
        if ($urandom_range(9) < 7)
          rid = 16'($urandom_range(16'h100B, 16'h1000));
      end else begin
        cmd = CMD_UNUSED;
      end
      add_beat(cmd, qty, value, rid, phase, fresh, fresh && phase == 2);
      if (!(cmd == CMD_UNUSED || (cmd == CMD_UPDATE && qty > QTY_MIL)))
        counted++;
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (beat_queue.size() != 0 || in_valid || replies_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Mismatches found");
    $finish;
  end

endmodule
